// File: rtl/dvd_pkg.sv
package dvd_pkg;

    // Number of distinct values the set holds (one cell per entry).
    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 32;

    // Item as it travels down the cell chain.
    typedef struct packed {
        logic               vld;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               hit;   // matched a stored entry
        logic               done;  // matched or stored; no further action
    } dvd_item_t;

endpackage

// File: rtl/dvd_cell.sv
module dvd_cell
    import dvd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  dvd_item_t item_in,
    output dvd_item_t item_out
);

    logic               used_reg;
    logic               used_next;
    logic [VALUE_W-1:0] stored_reg;
    dvd_item_t          item_reg;
    dvd_item_t          item_next;
    logic               live;
    logic               hit_here;
    logic               store_here;

    always_comb
    begin
        live       = item_in.vld && !item_in.done;
        hit_here   = live && used_reg && (stored_reg == item_in.value);
        store_here = live && !used_reg;

        item_next      = item_in;
        item_next.hit  = item_in.hit | hit_here;
        item_next.done = item_in.done | hit_here | store_here;

        // last item of a run empties the cell behind it
        if (item_in.vld && item_in.last)
        begin
            used_next = 1'b0;
        end
        else if (store_here)
        begin
            used_next = 1'b1;
        end
        else
        begin
            used_next = used_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            item_reg <= '0;
        end
        else if (adv)
        begin
            used_reg <= used_next;
            item_reg <= item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && store_here)
        begin
            stored_reg <= item_in.value;
        end
    end

    assign item_out = item_reg;

endmodule

// File: rtl/dvd_collect.sv
module dvd_collect
    import dvd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dvd_item_t item_in,
    input  logic      out_ready,
    output logic      adv,
    output logic      out_valid,
    output logic      has_duplicate,
    output logic      overflowed
);

    logic found_reg;
    logic found_next;
    logic ovf_reg;
    logic ovf_next;
    logic out_valid_reg;
    logic dup_reg;
    logic oflow_reg;

    // chain stalls only when a finished run meets an occupied result slot
    assign adv = !(item_in.vld && item_in.last && out_valid_reg && !out_ready);

    assign found_next = found_reg | item_in.hit;
    assign ovf_next   = ovf_reg | !item_in.done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv && item_in.vld)
            begin
                if (item_in.last)
                begin
                    found_reg <= 1'b0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    found_reg <= found_next;
                    ovf_reg   <= ovf_next;
                end
            end

            if (adv && item_in.vld && item_in.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && item_in.vld && item_in.last)
        begin
            dup_reg   <= found_next;
            oflow_reg <= ovf_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign has_duplicate = dup_reg;
    assign overflowed    = oflow_reg;

endmodule

// File: rtl/duplicate_value_detector.sv
// Result: a run's result is registered at the end of the chain once its last item
//   has passed through every cell; a pending result that is not taken can stall it.
// Throughput: one item per cycle; the chain freezes only when a run's last item
//   reaches the end while the previous result is still waiting to be taken.
// Reset (rst_n low, asynchronous): all cells empty, flags clear, no result pending.
module duplicate_value_detector
    import dvd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      last,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      has_duplicate,
    output logic                      overflowed
);

    // Systolic set: each item walks the chain one cell per cycle while adv is high. A
    // cell holding a value compares it against the passing item; the first empty cell
    // the item meets (when it has not matched) takes it. Since items never overtake
    // each other, every item sees the effect of all earlier items of its run.
    // A last item empties each cell as it passes, so the next run, following
    // behind, meets a clean chain. An item that leaves the chain neither matched
    // nor stored found the set full: that is an overflow.

    logic      adv;
    dvd_item_t chain [CAPACITY+1];

    // item entering cell 0; the chain only moves when adv, which is also ready
    always_comb
    begin
        chain[0]       = '0;
        chain[0].vld   = in_valid;
        chain[0].value = VALUE_W'(unsigned'(value));
        chain[0].last  = last;
        chain[0].hit   = 1'b0;
        chain[0].done  = 1'b0;
    end

    assign in_ready = adv;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        dvd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .item_in  (chain[i]),
            .item_out (chain[i+1])
        );
    end

    // end of the chain: per-run flags and the result register
    dvd_collect u_collect (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_in       (chain[CAPACITY]),
        .out_ready     (out_ready),
        .adv           (adv),
        .out_valid     (out_valid),
        .has_duplicate (has_duplicate),
        .overflowed    (overflowed)
    );

endmodule

// File: rtl/dvd_checker.sv
module dvd_checker (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic has_duplicate,
    input logic overflowed
);

    // pending result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(has_duplicate) && $stable(overflowed))
        else $error("result changed while stalled");

    // input side blocks only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a pending result");

    a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_ready && !out_valid)
        else $error("not ready after reset");

endmodule

bind duplicate_value_detector dvd_checker u_dvd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .has_duplicate (has_duplicate),
    .overflowed    (overflowed)
);

// File: sim/dvd_checker.sv
`timescale 1ns / 1ps

module dvd_scoreboard
    import dvd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      last,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic                      has_duplicate,
    input  logic                      overflowed,
    output int                        fail_count,
    output int                        verdicts_pending
);

    typedef struct packed {
        logic dup;
        logic ovf;
    } run_verdict_t;

    // Shadow copy of the distinct-value set and the flags of the open run.
    logic [VALUE_W-1:0] seen_set[$];
    logic               run_dup;
    logic               run_ovf;
    run_verdict_t       verdicts_due[$];
    run_verdict_t       oldest;
    int                 fails;

    task automatic absorb_value(input logic [VALUE_W-1:0] v, input logic is_last);
        logic         hit;
        run_verdict_t vd;
        hit = 1'b0;
        foreach (seen_set[i])
            if (seen_set[i] == v)
                hit = 1'b1;
        if (hit)
            run_dup = 1'b1;
        else if (seen_set.size() < CAPACITY)
            seen_set.push_back(v);
        else
            run_ovf = 1'b1;   // set full: value dropped
        if (is_last)
        begin
            vd.dup = run_dup;
            vd.ovf = run_ovf;
            verdicts_due.push_back(vd);
            seen_set.delete();
            run_dup = 1'b0;
            run_ovf = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_set.delete();
            verdicts_due.delete();
            run_dup = 1'b0;
            run_ovf = 1'b0;
            fails = 0;
            fail_count <= 0;
            verdicts_pending <= 0;
        end
        else
        begin
            // results first: a result leaving now always belongs to an older run
            if (out_valid && out_ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $error("result with no run closed: has_duplicate=%0b overflowed=%0b",
                           has_duplicate, overflowed);
                    fails++;
                end
                else
                begin
                    oldest = verdicts_due.pop_front();
                    if (has_duplicate !== oldest.dup)
                    begin
                        $error("has_duplicate: expected %0b, got %0b",
                               oldest.dup, has_duplicate);
                        fails++;
                    end
                    if (overflowed !== oldest.ovf)
                    begin
                        $error("overflowed: expected %0b, got %0b",
                               oldest.ovf, overflowed);
                        fails++;
                    end
                end
            end
            if (in_valid && in_ready)
                absorb_value(value, last);
            fail_count <= fails;
            verdicts_pending <= verdicts_due.size();
        end
    end

endmodule

// File: sim/duplicate_value_detector_test.sv
`timescale 1ns / 1ps

module duplicate_value_detector_test;
    import dvd_pkg::*;

    // Run shape
    localparam int ITEM_TARGET = 550;      // random part stops once this many items went in
    localparam int QUIET_TAIL  = 60;       // last items run with no idling on either side
    localparam int LONG_HOLD   = 300;      // receiver hold-off, well past the 64-cell chain
    // The limit is many times the slowest legal run, with sender gaps, receiver
    // stalls, the long hold-off and the midway and final drains all counted in.
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    logic                      out_valid;
    logic                      out_ready;
    logic                      has_duplicate;
    logic                      overflowed;

    int fail_count;
    int verdicts_pending;

    // Stimulus-side controls, all written with nonblocking assignments so the
    // receiver process reads the old value at the edge of a write, independent of process order.
    logic quiet;           // end of run: no idling anywhere
    int   hold_req;        // bumped by the sender to ask for one long hold-off
    int   hold_ack;        // receiver's copy once it has taken the request

    logic                calm;        // this run goes in with no sender gaps
    int                  items_sent;
    int                  cycle_count;
    logic [VALUE_W-1:0]  run_buf[$];  // values of the run being sent, in order
    logic [VALUE_W-1:0]  pool[64];

    duplicate_value_detector DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .value         (value),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .has_duplicate (has_duplicate),
        .overflowed    (overflowed)
    );

    dvd_scoreboard u_scoreboard (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .value            (value),
        .last             (last),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .has_duplicate    (has_duplicate),
        .overflowed       (overflowed),
        .fail_count       (fail_count),
        .verdicts_pending (verdicts_pending)
    );

    // 8 ns clock
    initial
        clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Offer one item, maybe after a short idle burst, and hold it until taken.
    // Called at a rising edge; returns at the edge where the item was accepted,
    // so the next call can keep valid high for back-to-back items.
    task automatic send_item(input logic [VALUE_W-1:0] v, input logic is_last);
        int gap;
        gap = 0;
        if (!quiet && !calm && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 5);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        last     <= is_last;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // Whole run from run_buf; the final item carries last.
    task automatic send_run();
        for (int i = 0; i < run_buf.size(); i++)
            send_item(run_buf[i], i == run_buf.size() - 1);
    endtask

    // Stop offering and wait for every closed run's result to come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (verdicts_pending != 0);
    endtask

    // Result side: random stall bursts, one long hold-off on request, and a
    // steady ready once the quiet tail begins.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        hold_ack  = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            stall = 0;
            if (hold_req != hold_ack)
            begin
                hold_ack <= hold_req;
                stall = LONG_HOLD;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
                stall = $urandom_range(1, 5);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[duplicate_value_detector] ERROR");
        $finish;
    end

    // Sender: directed runs, then random runs, then the verdict.
    initial
    begin
        int                 kind;
        int                 len;
        int                 psize;
        int                 runs_done;
        int                 fill_idx;
        int                 fill_n;
        int                 fill_tail;
        logic               paused;
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] stride;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        value      = '0;
        last       = 1'b0;
        quiet      = 1'b0;
        hold_req   = 0;
        calm       = 1'b0;
        items_sent = 0;
        runs_done  = 0;
        fill_idx   = 0;
        paused     = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Single-item run: can never be a duplicate.
        run_buf = '{32'h0000_0000};
        send_run();
        // Both extremes, -1 and 0, then the top value again closes the run.
        run_buf = '{VAL_MIN, VAL_MAX, 32'hFFFF_FFFF, 32'h0000_0000, VAL_MAX};
        send_run();
        // Alternating bit patterns and 1, all distinct: no duplicate.
        run_buf = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001};
        send_run();
        // Duplicate arriving on the last item itself.
        run_buf = '{32'h0000_0007, 32'h0000_0007};
        send_run();
        // Same value in consecutive runs: the set must be cleared in between.
        run_buf = '{VAL_MIN};
        send_run();
        run_buf = '{VAL_MIN, 32'h8000_0001, 32'hFFFF_FFFF};
        send_run();
        // Duplicate early, then more items: flag must stick to the end.
        run_buf = '{32'h1234_5678, 32'h1234_5678, 32'h0BAD_F00D, 32'h7FFF_FFFE};
        send_run();

        // Receiver goes dark for a long stretch while items keep coming; the
        // chain freezes behind the held result and in_ready must drop.
        hold_req <= hold_req + 1;

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= ITEM_TARGET - QUIET_TAIL)
                quiet <= 1'b1;
            // Once, midway, let everything drain before going on.
            if (!paused && items_sent >= ITEM_TARGET / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
            calm = ($urandom_range(0, 3) == 0);
            run_buf.delete();

            // A few scheduled runs that fill the set: overflow with a repeat of
            // a dropped value (not caught), exactly full with a repeat of a
            // stored value, and overflow with a stored repeat.
            if ((runs_done == 4 || runs_done == 35 || runs_done == 70) && fill_idx < 3)
            begin
                fill_n    = (fill_idx == 0) ? 66 : (fill_idx == 1) ? CAPACITY : 65;
                fill_tail = fill_idx;
                base      = $urandom;
                stride    = $urandom | 32'h1;  // odd stride: all values distinct
                for (int i = 0; i < fill_n; i++)
                    run_buf.push_back(base + stride * i);
                if (fill_tail == 0)
                    run_buf.push_back(base + stride * (fill_n - 1));
                else
                    run_buf.push_back(base + stride * $urandom_range(0, CAPACITY - 1));
                fill_idx++;
            end
            else
            begin
                kind = $urandom_range(0, 19);
                if (kind < 9)
                begin
                    // short run drawn from a tiny pool: duplicates are likely
                    psize = $urandom_range(1, 8);
                    for (int i = 0; i < psize; i++)
                        pool[i] = $urandom;
                    len = $urandom_range(1, 8);
                    for (int i = 0; i < len; i++)
                        run_buf.push_back(pool[$urandom_range(0, psize - 1)]);
                end
                else if (kind < 14)
                begin
                    // short run of fresh random values
                    len = $urandom_range(1, 8);
                    for (int i = 0; i < len; i++)
                        run_buf.push_back($urandom);
                end
                else if (kind < 17)
                begin
                    // longer run, pool size sets how often repeats hit
                    psize = $urandom_range(8, 64);
                    for (int i = 0; i < psize; i++)
                        pool[i] = $urandom;
                    len = $urandom_range(10, 40);
                    for (int i = 0; i < len; i++)
                        run_buf.push_back(pool[$urandom_range(0, psize - 1)]);
                end
                else
                begin
                    // values around the sign boundary and the extremes
                    pool[0] = VAL_MIN;
                    pool[1] = VAL_MAX;
                    pool[2] = 32'h0000_0000;
                    pool[3] = 32'hFFFF_FFFF;
                    pool[4] = 32'h0000_0001;
                    pool[5] = 32'h8000_0001;
                    len = $urandom_range(1, 6);
                    for (int i = 0; i < len; i++)
                        run_buf.push_back(pool[$urandom_range(0, 5)]);
                end
            end
            send_run();
            runs_done++;
        end

        drain_results();
        // Any stray result would show up within one pass of the chain.
        repeat (CAPACITY + 16) @(posedge clk);
        if (fail_count == 0)
            $display("[duplicate_value_detector] OK");
        else
            $display("[duplicate_value_detector] ERROR");
        $finish;
    end

endmodule
